FILE: hw/rtl/pairwise_correlation_threshold_assert.svh
// Assertion macros shared by the checker of the correlation block.
// Depends on nothing; included by pct_checker.sv.
`ifndef PAIRWISE_CORRELATION_THRESHOLD_ASSERT_SVH
`define PAIRWISE_CORRELATION_THRESHOLD_ASSERT_SVH

// Same-cycle implication
`define PCT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pct: implication check failed");

// Next-cycle implication
`define PCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pct: next-cycle check failed");

`endif

FILE: hw/rtl/pct_pkg.sv
// Shared types, constants and width helpers of the correlation block.
// No dependencies.
package pct_pkg;

  localparam int DEF_MAX_SERIES = 64;
  localparam int DEF_MAX_LEN    = 256;
  localparam int ROW_LIMIT      = 64;
  localparam int ONE_Q14        = 16384;
  localparam int DIV_STEPS      = 14;

  localparam int SER_W      = 6;
  localparam int TIME_W     = 8;
  localparam int SMP_W      = 16;
  localparam int CORR_W     = 16;
  localparam int THR_W      = 15;
  localparam int NSER_W     = 7;
  localparam int SLEN_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [NSER_W-1:0] RST_NUM_SERIES = 7'd64;
  localparam logic [SLEN_W-1:0] RST_SERIES_LEN = 9'd256;
  localparam logic [THR_W-1:0]  RST_EDGE_THR   = 15'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_SERIES = 2'd0,
    CFG_SERIES_LEN = 2'd1,
    CFG_EDGE_THR   = 2'd2
  } cfg_idx_t;

  typedef enum logic [0:0] {
    MODE_LOAD = 1'b0,
    MODE_ROW  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    SEL_VX  = 2'd0,
    SEL_VY  = 2'd1,
    SEL_NUM = 2'd2
  } mul_sel_t;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_ACC  = 10'b00_0000_0010,
    ST_MUL  = 10'b00_0000_0100,
    ST_CHK  = 10'b00_0000_1000,
    ST_PMUL = 10'b00_0001_0000,
    ST_SQL  = 10'b00_0010_0000,
    ST_SQRT = 10'b00_0100_0000,
    ST_DVL  = 10'b00_1000_0000,
    ST_DIV  = 10'b01_0000_0000,
    ST_OUT  = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic     acc_clr;
    logic     rd_en;
    logic     mul;
    logic     diff;
    mul_sel_t sel;
    logic     chk;
    logic     p_step;
    logic     s_load;
    logic     s_step;
    logic     d_load;
    logic     d_step;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_var;
    logic out_free;
  } dp_sts_t;

  // Bits of the length register for a given maximum length
  function automatic int len_w(input int max_len);
    return $clog2(max_len + 1);
  endfunction

  // Bits of the variance magnitudes and of the square root operand halves
  function automatic int vmag_w(input int max_len);
    return 2 * $clog2(max_len + 1) + 33;
  endfunction

endpackage

FILE: hw/rtl/pct_if.sv
// Stream interfaces of the correlation block: request and result channels.
// Depends on pct_pkg.
interface pct_in_if import pct_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [SER_W-1:0]        series_index;
  logic [TIME_W-1:0]       time_index;
  logic signed [SMP_W-1:0] sample_value;

  modport source (output valid, mode, series_index, time_index, sample_value,
                  input ready);
  modport sink   (input valid, mode, series_index, time_index, sample_value,
                  output ready);
endinterface

interface pct_out_if import pct_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [SER_W-1:0]         row_series;
  logic [SER_W-1:0]         partner_series;
  logic signed [CORR_W-1:0] correlation;
  logic                     edge_res;
  logic                     last;

  modport source (output valid, row_series, partner_series, correlation, edge_res, last,
                  input ready);
  modport sink   (input valid, row_series, partner_series, correlation, edge_res, last,
                  output ready);
endinterface

FILE: hw/rtl/pairwise_correlation_threshold.sv
// Load request: written to the store, no result.
// Row request for series i: one result per partner j>i; each pair runs the
// sum walk over both series, then the variance terms, the bit-serial product
// and root (VW = 2*clog2(MAX_LEN+1) + 33 bits wide) and the divide.
// No new request is taken while a row is in progress.
// Reset (synchronous, rst_n low): registers to 64 / 256 / 4096, sequencer idle,
// result empty; the sample store is not cleared.
module pairwise_correlation_threshold import pct_pkg::*; #(
  parameter int MAX_SERIES = DEF_MAX_SERIES,
  parameter int MAX_LEN    = DEF_MAX_LEN
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pct_in_if.sink                in_ch,
  pct_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LW = len_w(MAX_LEN);
  localparam int TW = $clog2(MAX_LEN);
  localparam int SER_LIMIT = (MAX_SERIES < ROW_LIMIT) ? MAX_SERIES : ROW_LIMIT;

  logic [NSER_W-1:0] num_series_r;
  logic [SLEN_W-1:0] series_len_r;
  logic [THR_W-1:0]  edge_thr_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_series_r <= RST_NUM_SERIES;
      series_len_r <= RST_SERIES_LEN;
      edge_thr_r   <= RST_EDGE_THR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_SERIES: num_series_r <= NSER_W'(cfg_data);
        CFG_SERIES_LEN: series_len_r <= SLEN_W'(cfg_data);
        CFG_EDGE_THR:   edge_thr_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective series count and length
  logic [NSER_W-1:0] n_eff;
  logic [LW-1:0]     len_eff;

  assign n_eff   = (32'(num_series_r) > SER_LIMIT) ? NSER_W'(SER_LIMIT) : num_series_r;
  assign len_eff = (32'(series_len_r) > MAX_LEN) ? LW'(MAX_LEN) : LW'(series_len_r);

  // Input beat decode
  logic in_accept, wr_en;
  assign in_accept = in_ch.valid && in_ch.ready;
  assign wr_en = in_accept && (in_ch.mode == MODE_LOAD)
              && (32'(in_ch.series_index) < MAX_SERIES)
              && (32'(in_ch.time_index) < MAX_LEN);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [TW-1:0]    rd_t;
  logic [SER_W-1:0] row, partner;
  logic             last;

  pct_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_accept(in_accept), .in_mode(in_ch.mode), .in_series(in_ch.series_index),
    .n_eff(n_eff), .len_eff(len_eff), .sts(sts), .cmd(cmd),
    .rd_t(rd_t), .row(row), .partner(partner), .last(last),
    .in_ready(in_ch.ready)
  );

  pct_dpath #(.MAX_SERIES(MAX_SERIES), .MAX_LEN(MAX_LEN)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .wr_en(wr_en), .wr_series(in_ch.series_index), .wr_time(in_ch.time_index),
    .wr_data(in_ch.sample_value),
    .rd_t(rd_t), .row(row), .partner(partner), .last(last),
    .len_eff(len_eff), .thr(edge_thr_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_row(out_ch.row_series), .out_partner(out_ch.partner_series),
    .out_corr(out_ch.correlation), .out_edge(out_ch.edge_res),
    .out_last(out_ch.last)
  );

endmodule

FILE: hw/rtl/pct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/pct_ctrl.sv
// Sequencer of the correlation block: walks partners, sums, and the
// multiply, square root and divide iterations. Depends on pct_pkg.
module pct_ctrl import pct_pkg::*; #(
  parameter int MAX_LEN    = DEF_MAX_LEN
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_accept,
  input  logic                         in_mode,
  input  logic [SER_W-1:0]             in_series,
  input  logic [NSER_W-1:0]            n_eff,
  input  logic [len_w(MAX_LEN)-1:0]    len_eff,
  input  dp_sts_t                      sts,
  output dp_cmd_t                      cmd,
  output logic [$clog2(MAX_LEN)-1:0]   rd_t,
  output logic [SER_W-1:0]             row,
  output logic [SER_W-1:0]             partner,
  output logic                         last,
  output logic                         in_ready
);

  localparam int LW  = len_w(MAX_LEN);
  localparam int TW  = $clog2(MAX_LEN);
  localparam int VW  = vmag_w(MAX_LEN);
  localparam int CW  = (LW + 1 > 7) ? LW + 1 : 7;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [SER_W-1:0]  row_r, row_nxt;
  logic [NSER_W-1:0] j_r, j_nxt;
  logic              row_go;

  assign row_go  = (7'(in_series) + 7'd1) < n_eff;
  assign row     = row_r;
  assign partner = j_r[SER_W-1:0];
  assign last    = (j_r == n_eff - 7'd1);
  assign rd_t    = TW'(cnt_r);
  assign in_ready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    row_nxt   = row_r;
    j_nxt     = j_r;
    cmd       = '0;
    cmd.sel   = SEL_VX;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_mode == MODE_ROW) && row_go) begin
          row_nxt     = in_series;
          j_nxt       = 7'(in_series) + 7'd1;
          cnt_nxt     = '0;
          cmd.acc_clr = 1'b1;
          state_nxt   = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.rd_en = (cnt_r < CW'(len_eff));
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CW'(len_eff) + 1'b1) begin
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // even count: products, odd count: difference
        cmd.mul  = ~cnt_r[0];
        cmd.diff = cnt_r[0];
        cmd.sel  = mul_sel_t'(cnt_r[2:1]);
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CW'(5)) begin
          cnt_nxt   = '0;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = sts.zero_var ? ST_OUT : ST_PMUL;
      end
      ST_PMUL: begin
        cmd.p_step = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CW'(VW - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SQL;
        end
      end
      ST_SQL: begin
        cmd.s_load = 1'b1;
        state_nxt  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.s_step = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CW'(VW - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DVL;
        end
      end
      ST_DVL: begin
        cmd.d_load = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.d_step = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (last) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt       = j_r + 7'd1;
            cnt_nxt     = '0;
            cmd.acc_clr = 1'b1;
            state_nxt   = ST_ACC;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      row_r   <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      row_r   <= row_nxt;
      j_r     <= j_nxt;
    end
  end

endmodule

FILE: hw/rtl/pct_dpath.sv
// Datapath of the correlation block: sample store, running sums, variance
// terms, shift-add product, digit square root, divider, result register.
// Depends on pct_pkg and pct_ram.
module pct_dpath import pct_pkg::*; #(
  parameter int MAX_SERIES = DEF_MAX_SERIES,
  parameter int MAX_LEN    = DEF_MAX_LEN
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  output dp_sts_t                    sts,
  input  logic                       wr_en,
  input  logic [SER_W-1:0]           wr_series,
  input  logic [TIME_W-1:0]          wr_time,
  input  logic signed [SMP_W-1:0]    wr_data,
  input  logic [$clog2(MAX_LEN)-1:0] rd_t,
  input  logic [SER_W-1:0]           row,
  input  logic [SER_W-1:0]           partner,
  input  logic                       last,
  input  logic [len_w(MAX_LEN)-1:0]  len_eff,
  input  logic [THR_W-1:0]           thr,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [SER_W-1:0]           out_row,
  output logic [SER_W-1:0]           out_partner,
  output logic signed [CORR_W-1:0]   out_corr,
  output logic                       out_edge,
  output logic                       out_last
);

  localparam int DEPTH = MAX_SERIES * MAX_LEN;
  localparam int AW = $clog2(DEPTH);
  localparam int LW = len_w(MAX_LEN);
  localparam int SW = SMP_W + LW;
  localparam int XW = 32 + LW;
  localparam int VW = vmag_w(MAX_LEN);
  localparam int PW = VW + 1;
  localparam int QW = DIV_STEPS;

  // Sample store, mirrored so that both series read in the same cycle
  logic [AW-1:0] waddr, raddr_x, raddr_y;
  logic [SMP_W-1:0] rdata_x, rdata_y;

  assign waddr   = AW'(wr_series) * AW'(MAX_LEN) + AW'(wr_time);
  assign raddr_x = AW'(row) * AW'(MAX_LEN) + AW'(rd_t);
  assign raddr_y = AW'(partner) * AW'(MAX_LEN) + AW'(rd_t);

  pct_ram #(.WIDTH(SMP_W), .DEPTH(DEPTH)) u_ram_x (
    .clk(clk), .we(wr_en), .waddr(waddr), .wdata(wr_data),
    .raddr(raddr_x), .rdata(rdata_x)
  );

  pct_ram #(.WIDTH(SMP_W), .DEPTH(DEPTH)) u_ram_y (
    .clk(clk), .we(wr_en), .waddr(waddr), .wdata(wr_data),
    .raddr(raddr_y), .rdata(rdata_y)
  );

  // Read pipeline: data valid, then products, then sums
  logic v1_r, v2_r;
  logic signed [SMP_W-1:0] x, y, xd_r, yd_r;
  logic signed [31:0] xx_r, yy_r, xy_r;
  logic signed [SW-1:0] sx_r, sy_r;
  logic signed [XW-1:0] sxx_r, syy_r, sxy_r;

  assign x = $signed(rdata_x);
  assign y = $signed(rdata_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    xd_r <= x;
    yd_r <= y;
    xx_r <= 32'(x) * 32'(x);
    yy_r <= 32'(y) * 32'(y);
    xy_r <= 32'(x) * 32'(y);
    if (cmd.acc_clr) begin
      sx_r  <= '0;
      sy_r  <= '0;
      sxx_r <= '0;
      syy_r <= '0;
      sxy_r <= '0;
    end else if (v2_r) begin
      sx_r  <= sx_r + SW'(xd_r);
      sy_r  <= sy_r + SW'(yd_r);
      sxx_r <= sxx_r + XW'(xx_r);
      syy_r <= syy_r + XW'(yy_r);
      sxy_r <= sxy_r + XW'(xy_r);
    end
  end

  // Variance and covariance terms: L*A - B*C, products then difference per term
  logic signed [XW-1:0] a_sel;
  logic signed [SW-1:0] b_sel, c_sel;
  logic signed [LW:0]   len_s;
  logic signed [PW-1:0] m1_r, m2_r, dif, vx_r, vy_r, num_r;

  assign len_s = $signed({1'b0, len_eff});
  assign dif   = m1_r - m2_r;

  always_comb begin
    case (cmd.sel)
      SEL_VX:  begin a_sel = sxx_r; b_sel = sx_r; c_sel = sx_r; end
      SEL_VY:  begin a_sel = syy_r; b_sel = sy_r; c_sel = sy_r; end
      SEL_NUM: begin a_sel = sxy_r; b_sel = sx_r; c_sel = sy_r; end
      default: begin a_sel = sxy_r; b_sel = sx_r; c_sel = sy_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      m1_r <= PW'(len_s) * PW'(a_sel);
      m2_r <= PW'(b_sel) * PW'(c_sel);
    end
    if (cmd.diff) begin
      case (cmd.sel)
        SEL_VX:  vx_r  <= dif;
        SEL_VY:  vy_r  <= dif;
        default: num_r <= dif;
      endcase
    end
  end

  assign sts.zero_var = vx_r[PW-1] || (vx_r == '0) || vy_r[PW-1] || (vy_r == '0);

  // Product vx*vy by shift-add, then floor square root two bits a step
  logic [VW-1:0] hi_r, lo_r, root_r;
  logic [VW:0]   psum;
  logic [VW+1:0] rem_r, rem_sh, trial;
  logic          zero_r;

  assign psum   = {1'b0, hi_r} + (lo_r[0] ? {1'b0, VW'(vy_r)} : '0);
  assign rem_sh = {rem_r[VW-1:0], hi_r[VW-1:VW-2]};
  assign trial  = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.chk) begin
      zero_r <= sts.zero_var;
      hi_r   <= '0;
      lo_r   <= VW'(vx_r);
    end else if (cmd.p_step) begin
      hi_r <= psum[VW:1];
      lo_r <= {psum[0], lo_r[VW-1:1]};
    end else if (cmd.s_step) begin
      {hi_r, lo_r} <= {hi_r[VW-3:0], lo_r, 2'b00};
    end
    if (cmd.s_load) begin
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.s_step) begin
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[VW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[VW-2:0], 1'b0};
      end
    end
  end

  // Restoring divide |num| / den for fourteen fraction bits
  logic signed [PW-1:0] num_abs;
  logic [VW-1:0] mag, r_r;
  logic [VW:0]   dshift;
  logic [QW-1:0] q_r;
  logic          neg_r, sat_r;

  assign num_abs = num_r[PW-1] ? -num_r : num_r;
  assign mag     = VW'(num_abs);
  assign dshift  = {r_r, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.d_load) begin
      neg_r <= num_r[PW-1];
      sat_r <= (mag >= root_r);
      r_r   <= mag;
      q_r   <= '0;
    end else if (cmd.d_step) begin
      if (dshift >= {1'b0, root_r}) begin
        r_r <= VW'(dshift - {1'b0, root_r});
        q_r <= {q_r[QW-2:0], 1'b1};
      end else begin
        r_r <= VW'(dshift);
        q_r <= {q_r[QW-2:0], 1'b0};
      end
    end
  end

  // Result assembly and output register
  logic [THR_W-1:0]        cmag;
  logic signed [CORR_W-1:0] corr;
  logic                     ov_r;

  always_comb begin
    if (zero_r) begin
      cmag = '0;
    end else if (sat_r) begin
      cmag = THR_W'(ONE_Q14);
    end else begin
      cmag = THR_W'(q_r);
    end
  end

  assign corr = (neg_r && !zero_r) ? -$signed(CORR_W'(cmag)) : $signed(CORR_W'(cmag));
  assign sts.out_free = !ov_r || out_ready;
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row     <= row;
      out_partner <= partner;
      out_corr    <= corr;
      out_edge    <= (cmag > thr);
      out_last    <= last;
    end
  end

endmodule

FILE: hw/rtl/pct_checker.sv
// Port-level checks on the result channel of the correlation block.
// Depends on pairwise_correlation_threshold_assert.svh; bound to the top level.
`include "pairwise_correlation_threshold_assert.svh"

module pct_port_assert (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [5:0]        row_series,
  input logic [5:0]        partner_series,
  input logic signed [15:0] correlation,
  input logic              edge_res
);

  // A pending beat is held until taken
  `PCT_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // Pairs come from the upper triangle
  `PCT_ASSERT_IMPLY(a_upper, clk, rst_n, out_valid, partner_series > row_series)

  // Correlation stays within plus and minus one in Q2.14
  `PCT_ASSERT_IMPLY(a_range, clk, rst_n, out_valid,
    (correlation <= 16'sd16384) && (correlation >= -16'sd16384))

  // An edge never marks a zero correlation
  `PCT_ASSERT_IMPLY(a_edge, clk, rst_n, out_valid && edge_res, correlation != 16'sd0)

endmodule

bind pairwise_correlation_threshold pct_port_assert u_pct_port_assert (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .row_series(out_ch.row_series),
  .partner_series(out_ch.partner_series),
  .correlation(out_ch.correlation),
  .edge_res(out_ch.edge_res)
);
